>>> rtl/core/assert_macros.svh
// Concurrent assertion helpers, clocked on i_clk, off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/pgwalk_pkg.sv
package pgwalk_pkg;

    localparam int VA_W      = 48;
    localparam int ENTRY_W   = 64;
    localparam int FRAME_W   = 51;
    localparam int IDX_W     = 9;
    localparam int INDICES_W = 36;
    localparam int BASE_W    = 52;   // bits 63..12 of a table or page base
    localparam int S_DATA_W  = 112;
    localparam int M_DATA_W  = 120;

    localparam logic FUNC_TRANSLATE = 1'b0;
    localparam logic FUNC_ENTRY     = 1'b1;

    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_RESULT = 1'b1;

    localparam logic [1:0] SIZE_4K = 2'd0;
    localparam logic [1:0] SIZE_2M = 2'd1;
    localparam logic [1:0] SIZE_1G = 2'd2;

    localparam logic [1:0] LEVEL_TOP = 2'd3;
    localparam logic [1:0] LEVEL_1G  = 2'd2;
    localparam logic [1:0] LEVEL_2M  = 2'd1;
    localparam logic [1:0] LEVEL_4K  = 2'd0;

    localparam int PRESENT_BIT = 0;
    localparam int LARGE_BIT   = 7;

    typedef enum logic [2:0] {
        OP_READ,
        OP_UNMAPPED,
        OP_PAGE_4K,
        OP_PAGE_2M,
        OP_PAGE_1G
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [BASE_W-1:0]  base;
        logic [IDX_W-1:0]   index;
    } t_cmd;

endpackage

>>> rtl/core/pgwalk_front.sv
`include "assert_macros.svh"

module pgwalk_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [pgwalk_pkg::ENTRY_W-1:0]      i_cfg_data,
    input  logic                                i_accept,
    input  logic                                i_func,
    input  logic [pgwalk_pkg::VA_W-1:0]         i_virt_addr,
    input  logic [pgwalk_pkg::ENTRY_W-1:0]      i_entry_data,
    output logic                                o_push,
    output pgwalk_pkg::t_cmd                    o_cmd
);

    logic                                   r_busy, n_busy;
    logic [1:0]                             r_level, n_level;
    logic [pgwalk_pkg::INDICES_W-1:0]       r_indices, n_indices;
    logic [pgwalk_pkg::ENTRY_W-1:0]         r_root, n_root;
    logic [pgwalk_pkg::BASE_W-1:0]          entry_base;
    logic                                   present, large_page;

    function automatic logic [pgwalk_pkg::IDX_W-1:0] index_of(
        input logic [pgwalk_pkg::INDICES_W-1:0] indices,
        input logic [1:0]                       level
    );
        logic [pgwalk_pkg::IDX_W-1:0] idx;
        unique case (level)
            pgwalk_pkg::LEVEL_TOP: idx = indices[35:27];
            pgwalk_pkg::LEVEL_1G:  idx = indices[26:18];
            pgwalk_pkg::LEVEL_2M:  idx = indices[17:9];
            default:               idx = indices[8:0];
        endcase
        return idx;
    endfunction

    // bit 63 of an entry is not part of the next table address
    assign entry_base = {1'b0, i_entry_data[62:12]};
    assign present    = i_entry_data[pgwalk_pkg::PRESENT_BIT];
    assign large_page = i_entry_data[pgwalk_pkg::LARGE_BIT];

    always_comb begin
        n_busy    = r_busy;
        n_level   = r_level;
        n_indices = r_indices;
        n_root    = i_cfg_valid ? i_cfg_data : r_root;
        o_push    = 1'b0;
        o_cmd     = '{op: pgwalk_pkg::OP_READ, base: entry_base, index: '0};
        if (i_accept) begin
            if (i_func == pgwalk_pkg::FUNC_TRANSLATE) begin
                n_busy    = 1'b1;
                n_level   = pgwalk_pkg::LEVEL_TOP;
                n_indices = i_virt_addr[47:12];
                o_push    = 1'b1;
                o_cmd     = '{op: pgwalk_pkg::OP_READ, base: r_root[63:12],
                              index: i_virt_addr[47:39]};
            end else if (r_busy) begin
                o_push = 1'b1;
                if (!present) begin
                    n_busy   = 1'b0;
                    o_cmd.op = pgwalk_pkg::OP_UNMAPPED;
                end else if (r_level == pgwalk_pkg::LEVEL_1G && large_page) begin
                    n_busy   = 1'b0;
                    o_cmd.op = pgwalk_pkg::OP_PAGE_1G;
                end else if (r_level == pgwalk_pkg::LEVEL_2M && large_page) begin
                    n_busy   = 1'b0;
                    o_cmd.op = pgwalk_pkg::OP_PAGE_2M;
                end else if (r_level == pgwalk_pkg::LEVEL_4K) begin
                    n_busy   = 1'b0;
                    o_cmd.op = pgwalk_pkg::OP_PAGE_4K;
                end else begin
                    n_level     = r_level - 2'd1;
                    o_cmd.index = index_of(r_indices, n_level);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_level   <= '0;
            r_indices <= '0;
            r_root    <= '0;
        end else begin
            r_busy    <= n_busy;
            r_level   <= n_level;
            r_indices <= n_indices;
            r_root    <= n_root;
        end
    end

    `ASSERT_NEXT(a_walk_start, i_accept && i_func == pgwalk_pkg::FUNC_TRANSLATE, r_busy && r_level == pgwalk_pkg::LEVEL_TOP)
    `ASSERT_SAME(a_idle_data_dropped, i_accept && i_func == pgwalk_pkg::FUNC_ENTRY && !r_busy, !o_push)

endmodule

>>> rtl/core/pgwalk_queue.sv
`include "assert_macros.svh"

module pgwalk_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pgwalk_pkg::t_cmd    i_cmd,
    output logic                o_full,
    output logic                o_empty,
    input  logic                i_pop,
    output pgwalk_pkg::t_cmd    o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pgwalk_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    `ASSERT_SAME(a_no_overflow, i_push, !o_full)
    `ASSERT_SAME(a_no_underflow, i_pop, !o_empty)

endmodule

>>> rtl/core/pgwalk_back.sv
module pgwalk_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_empty,
    input  pgwalk_pkg::t_cmd                    i_cmd,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_kind,
    output logic [pgwalk_pkg::M_DATA_W-1:0]     o_data
);

    logic                               r_valid;
    logic                               r_kind, n_kind;
    logic [pgwalk_pkg::M_DATA_W-1:0]    r_data, n_data;
    logic [pgwalk_pkg::ENTRY_W-1:0]     read_addr;
    logic                               mapped;
    logic [1:0]                         page_size;
    logic [pgwalk_pkg::FRAME_W-1:0]     frame;

    assign o_pop = !i_empty && (!r_valid || i_ready);

    always_comb begin
        read_addr = '0;
        mapped    = 1'b0;
        page_size = pgwalk_pkg::SIZE_4K;
        frame     = '0;
        n_kind    = pgwalk_pkg::KIND_RESULT;
        unique case (i_cmd.op)
            pgwalk_pkg::OP_READ: begin
                // base is 4 KB aligned and index*8 stays below 4 KB
                n_kind    = pgwalk_pkg::KIND_READ;
                read_addr = {i_cmd.base, i_cmd.index, 3'b000};
            end
            pgwalk_pkg::OP_PAGE_4K: begin
                mapped = 1'b1;
                frame  = i_cmd.base[50:0];
            end
            pgwalk_pkg::OP_PAGE_2M: begin
                mapped    = 1'b1;
                page_size = pgwalk_pkg::SIZE_2M;
                frame     = {9'd0, i_cmd.base[50:9]};
            end
            pgwalk_pkg::OP_PAGE_1G: begin
                mapped    = 1'b1;
                page_size = pgwalk_pkg::SIZE_1G;
                frame     = {18'd0, i_cmd.base[50:18]};
            end
            default: begin
                mapped = 1'b0;
            end
        endcase
        n_data = {2'b00, frame, page_size, mapped, read_addr};
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= n_kind;
            r_data <= n_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_data  = r_data;

endmodule

>>> rtl/core/four_level_page_table_walker.sv
// Four-level page table walker. A translate request (tuser 0) emits a read
// request for the top-level entry; each returned entry (tuser 1) emits either
// the read request for the next level or the final result (mapped flag, page
// size, frame number). A new translate request abandons any walk in progress;
// entries arriving with no walk open are dropped. The block takes one item per
// cycle on each side, stalling only on a full queue (input) or low m_tready
// (output): the front classifies an item and updates the walk state in the
// cycle it is accepted, a QUEUE_DEPTH-entry queue decouples it from the back
// end; each result passes the queue, then the output register. The user must
// write table_root via the cfg port while no walk is in flight (not enforced).
module four_level_page_table_walker #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [63:0]                         i_cfg_data,    // table_root
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [pgwalk_pkg::S_DATA_W-1:0]     i_s_tdata,     // virt_addr, entry_data
    input  logic [0:0]                          i_s_tuser,     // func
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // read_addr, mapped, page_size, frame_number, 2 bits zero pad
    output logic [pgwalk_pkg::M_DATA_W-1:0]     o_m_tdata,
    output logic [0:0]                          o_m_tuser      // kind
);

    logic               accept;
    logic               push, pop, full, empty;
    pgwalk_pkg::t_cmd   front_cmd, back_cmd;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !full;
    assign accept      = i_s_tvalid && !full;

    pgwalk_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_func       (i_s_tuser[0]),
        .i_virt_addr  (i_s_tdata[47:0]),
        .i_entry_data (i_s_tdata[111:48]),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    pgwalk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_cmd   (back_cmd)
    );

    pgwalk_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (back_cmd),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_kind  (o_m_tuser[0]),
        .o_data  (o_m_tdata)
    );

endmodule
